// ===== rtl/core/bfre_pkg.sv =====
// Shared types, constants and a saturating helper for the bitmap free-run extractor.
`timescale 1ns / 1ps

package bfre_pkg;

	localparam int NUM_LANES  = 8;
	localparam int NUM_SLOTS  = NUM_LANES + 2;
	localparam int SLOT_FLUSH = NUM_LANES;
	localparam int SLOT_SUM   = NUM_LANES + 1;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	localparam logic KIND_RUN = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	typedef enum logic [1:0] {
		REG_BLOCK_BYTES = 2'd0,
		REG_AREA_LIMIT  = 2'd1,
		REG_AREA_BASE   = 2'd2
	} cfg_reg_t;

	// Scan state carried from one bitmap byte to the next
	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] run_start;
		logic [31:0] run_len;
		logic [30:0] tally;
		logic        stopped;
	} scan_st_t;

	// One pending result; start is the raw position, base is added on the way out
	typedef struct packed {
		logic        kind;
		logic [31:0] start;
		logic [31:0] len;
		logic [30:0] used;
	} slot_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== rtl/core/bfre_lane.sv =====
// One bit lane: block position after this bit and whether it reaches the limit.
`timescale 1ns / 1ps

module bfre_lane (
	input  logic [31:0] pos,
	input  logic [15:0] bb,
	input  logic [30:0] limit,
	input  logic [3:0]  steps,
	output logic [31:0] pos_after,
	output logic        hit
);

	logic [19:0] prod;

	assign prod      = {16'b0, steps} * {4'b0, bb};
	assign pos_after = bfre_pkg::sat_add32(pos, {12'b0, prod});
	assign hit       = pos_after >= {1'b0, limit};

endmodule

// ===== rtl/core/bfre_merge.sv =====
// Merge stage: combine lane results into run extents, summary and next scan state.
`timescale 1ns / 1ps

module bfre_merge (
	input  logic [7:0]                                      bits,
	input  logic                                            fin,
	input  bfre_pkg::scan_st_t                              cur,
	input  logic [15:0]                                     bb,
	input  logic [bfre_pkg::NUM_LANES-1:0][31:0]            lane_pos,
	input  logic [bfre_pkg::NUM_LANES-1:0]                  lane_hit,
	output bfre_pkg::scan_st_t                              nxt,
	output logic [bfre_pkg::NUM_SLOTS-1:0]                  slot_vld,
	output bfre_pkg::slot_t [bfre_pkg::NUM_SLOTS-1:0]       slots
);

	logic [bfre_pkg::NUM_LANES-1:0][3:0]  k_at;
	logic [bfre_pkg::NUM_LANES-1:0][3:0]  ones_at;
	logic [bfre_pkg::NUM_LANES-1:0][31:0] sstart_at;
	logic [bfre_pkg::NUM_LANES-1:0]       seen_at;
	logic [bfre_pkg::NUM_LANES-1:0]       cand;
	logic [3:0]  k_end;
	logic [3:0]  ones_end;
	logic [31:0] sstart_end;
	logic        seen_end;
	logic [31:0] pos_end;
	logic        stop_end;
	logic [31:0] len_end;
	logic [31:0] start_end;
	logic [30:0] tally_end;

	function automatic logic [31:0] run_len(input logic [31:0] carried, input logic seen,
			input logic [3:0] k, input logic [15:0] blk);
		logic [19:0] prod;
		prod = {16'b0, k} * {4'b0, blk};
		return bfre_pkg::sat_add32(seen ? 32'd0 : carried, {12'b0, prod});
	endfunction

	function automatic logic [30:0] sat_tally(input logic [30:0] t, input logic [3:0] n);
		logic [31:0] s;
		s = {1'b0, t} + {28'b0, n};
		return s[31] ? bfre_pkg::SAT31 : s[30:0];
	endfunction

	// Prefix walk over the lanes: zero streak, seen-one flag, streak start, ones count
	always_comb begin
		logic [31:0] pb;
		logic        stop;
		logic [3:0]  k;
		logic        seen;
		logic [31:0] sstart;
		logic [3:0]  ones;
		pb     = cur.pos;
		stop   = cur.stopped;
		k      = 4'd0;
		seen   = 1'b0;
		sstart = cur.run_start;
		ones   = 4'd0;
		for (int i = 0; i < bfre_pkg::NUM_LANES; i++) begin
			cand[i]      = !stop && bits[i];
			k_at[i]      = k;
			seen_at[i]   = seen;
			sstart_at[i] = sstart;
			ones_at[i]   = ones;
			if (!stop) begin
				if (bits[i]) begin
					seen = 1'b1;
					k    = 4'd0;
					ones = ones + 4'd1;
				end else begin
					if (k == 4'd0)
						sstart = pb;
					k = k + 4'd1;
				end
				pb   = lane_pos[i];
				stop = lane_hit[i];
			end
		end
		k_end      = k;
		seen_end   = seen;
		sstart_end = sstart;
		ones_end   = ones;
		pos_end    = pb;
		stop_end   = stop;
	end

	assign len_end   = run_len(cur.run_len, seen_end, k_end, bb);
	assign start_end = (!seen_end && cur.run_len != 32'd0) ? cur.run_start : sstart_end;
	assign tally_end = sat_tally(cur.tally, ones_end);

	// Per-lane extent closed by an allocated bit, then the flush of the open run
	// and the end summary on the final byte
	always_comb begin
		logic [31:0] len;
		for (int i = 0; i < bfre_pkg::NUM_LANES; i++) begin
			len              = run_len(cur.run_len, seen_at[i], k_at[i], bb);
			slot_vld[i]      = cand[i] && (len != 32'd0);
			slots[i].kind    = bfre_pkg::KIND_RUN;
			slots[i].start   = (!seen_at[i] && cur.run_len != 32'd0) ? cur.run_start
			                                                          : sstart_at[i];
			slots[i].len     = len;
			slots[i].used    = sat_tally(cur.tally, ones_at[i]);
		end
		slot_vld[bfre_pkg::SLOT_FLUSH]    = fin && (len_end != 32'd0);
		slots[bfre_pkg::SLOT_FLUSH].kind  = bfre_pkg::KIND_RUN;
		slots[bfre_pkg::SLOT_FLUSH].start = start_end;
		slots[bfre_pkg::SLOT_FLUSH].len   = len_end;
		slots[bfre_pkg::SLOT_FLUSH].used  = tally_end;
		slot_vld[bfre_pkg::SLOT_SUM]      = fin;
		slots[bfre_pkg::SLOT_SUM].kind    = bfre_pkg::KIND_SUM;
		slots[bfre_pkg::SLOT_SUM].start   = 32'd0;
		slots[bfre_pkg::SLOT_SUM].len     = 32'd0;
		slots[bfre_pkg::SLOT_SUM].used    = tally_end;
	end

	always_comb begin
		if (fin) begin
			nxt = '0;
		end else begin
			nxt.pos       = pos_end;
			nxt.run_start = start_end;
			nxt.run_len   = len_end;
			nxt.tally     = tally_end;
			nxt.stopped   = stop_end;
		end
	end

endmodule

// ===== rtl/core/bfre_emit.sv =====
// Result queue: hold one byte's result slots and send them out one per cycle while out_stall is low.
`timescale 1ns / 1ps

module bfre_emit (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  logic [bfre_pkg::NUM_SLOTS-1:0]             slot_vld,
	input  bfre_pkg::slot_t [bfre_pkg::NUM_SLOTS-1:0]  slots,
	input  logic [30:0]                                base,
	input  logic                                       out_stall,
	output logic                                       busy,
	output logic                                       out_valid,
	output logic                                       result_kind,
	output logic [31:0]                                run_start,
	output logic [31:0]                                run_bytes,
	output logic [30:0]                                used_blocks,
	output logic                                       end_of_run_list
);

	logic [bfre_pkg::NUM_SLOTS-1:0]            pend_q;
	bfre_pkg::slot_t [bfre_pkg::NUM_SLOTS-1:0] slots_s1;
	logic [bfre_pkg::NUM_SLOTS-1:0]            pick_oh;
	logic [bfre_pkg::NUM_SLOTS-1:0]            pend_next;
	bfre_pkg::slot_t                           pick;
	logic                                      take;
	logic                                      out_valid_q;
	logic                                      kind_q;
	logic [31:0]                               start_q;
	logic [31:0]                               len_q;
	logic [30:0]                               used_q;
	logic                                      last_q;

	// Lowest pending slot goes first, which keeps the bit order
	assign pick_oh = pend_q & (~pend_q + {{(bfre_pkg::NUM_SLOTS-1){1'b0}}, 1'b1});

	always_comb begin
		pick = '0;
		for (int s = 0; s < bfre_pkg::NUM_SLOTS; s++) begin
			if (pick_oh[s])
				pick = bfre_pkg::slot_t'(pick | slots_s1[s]);
		end
	end

	assign take      = (|pend_q) && (!out_valid_q || !out_stall);
	assign pend_next = take ? (pend_q & ~pick_oh) : pend_q;
	assign busy      = |pend_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= slot_vld;
		end else begin
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			slots_s1 <= slots;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= pick.kind;
			start_q <= (pick.kind == bfre_pkg::KIND_SUM) ? 32'd0
			           : bfre_pkg::sat_add32({1'b0, base}, pick.start);
			len_q   <= pick.len;
			used_q  <= pick.used;
			last_q  <= (pend_next == '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign run_start       = start_q;
	assign run_bytes       = len_q;
	assign used_blocks     = used_q;
	assign end_of_run_list = last_q;

endmodule

// ===== rtl/core/bitmap_free_run_extractor_unit.sv =====
// Top level of the bitmap free-run extractor: config registers, scan state, lanes, merge, queue.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one allocation-bitmap byte per transaction,
//   bit 0 first, 1 = allocated block, with final_byte marking the last byte of a table.
//   Output channel (out_valid / out_stall) carries result transactions: free-run extents
//   (start = area_base + position, length in bytes) and, after the final byte, a summary
//   holding the allocated block count. end_of_run_list marks the last result of a byte.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready; write it
//   only while no results are outstanding.
// Pipeline and rate:
//   Eight bit lanes and the merge stage evaluate a whole byte in the accept cycle; its
//   results are registered in the result queue and then pass one at a time through the
//   single output register, which delivers one result per cycle while out_stall is low;
//   a byte has 0 to 6 results, and unstalled bytes with at most one result stream every cycle.
// Reset:
//   Clears the scan state and pending results; block_bytes = 1, area_limit = 0x7FFFFFFF,
//   area_base = 0. A final byte also returns the scan state to zero.
// Stall:
//   A stalled output holds its result; pending results then back up and in_stall rises
//   until the queue of the current byte can drain.

module bitmap_free_run_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  table_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [31:0] run_start,
	output logic [31:0] run_bytes,
	output logic [30:0] used_blocks,
	output logic        end_of_run_list,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [15:0] bb_q;
	logic [30:0] limit_q;
	logic [30:0] base_q;

	bfre_pkg::scan_st_t st_q;
	bfre_pkg::scan_st_t st_nxt;

	logic [bfre_pkg::NUM_LANES-1:0][31:0]      lane_pos;
	logic [bfre_pkg::NUM_LANES-1:0]            lane_hit;
	logic [bfre_pkg::NUM_SLOTS-1:0]            slot_vld;
	bfre_pkg::slot_t [bfre_pkg::NUM_SLOTS-1:0] slots;
	logic                                      in_acc;
	logic                                      busy;

	// Registers take writes at any time; the scan sees them on the next byte
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q    <= 16'd1;
			limit_q <= bfre_pkg::SAT31;
			base_q  <= 31'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bfre_pkg::cfg_reg_t'(cfg_index))
				bfre_pkg::REG_BLOCK_BYTES: bb_q    <= cfg_data[15:0];
				bfre_pkg::REG_AREA_LIMIT:  limit_q <= cfg_data[30:0];
				bfre_pkg::REG_AREA_BASE:   base_q  <= cfg_data[30:0];
				default: begin
					// unknown register: drop the write
				end
			endcase
		end
	end

	// Each lane works out the block position after its own bit and the limit test
	for (genvar i = 0; i < bfre_pkg::NUM_LANES; i++) begin : g_lane
		bfre_lane u_lane (
			.pos       (st_q.pos),
			.bb        (bb_q),
			.limit     (limit_q),
			.steps     (4'(i + 1)),
			.pos_after (lane_pos[i]),
			.hit       (lane_hit[i])
		);
	end

	// Merge the lanes into extents, the summary and the next scan state
	bfre_merge u_merge (
		.bits     (table_byte),
		.fin      (final_byte),
		.cur      (st_q),
		.bb       (bb_q),
		.lane_pos (lane_pos),
		.lane_hit (lane_hit),
		.nxt      (st_nxt),
		.slot_vld (slot_vld),
		.slots    (slots)
	);

	// Accept a byte once the previous byte's results are all on their way out
	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	bfre_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (in_acc),
		.slot_vld        (slot_vld),
		.slots           (slots),
		.base            (base_q),
		.out_stall       (out_stall),
		.busy            (busy),
		.out_valid       (out_valid),
		.result_kind     (result_kind),
		.run_start       (run_start),
		.run_bytes       (run_bytes),
		.used_blocks     (used_blocks),
		.end_of_run_list (end_of_run_list)
	);

	// A final byte returns the scan to its start
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && final_byte |=> st_q == '0)
		else $error("scan state not cleared after final byte");

	// A stopped scan no longer moves the block position
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !final_byte && st_q.stopped |=> $stable(st_q.pos) && st_q.stopped)
		else $error("stopped scan advanced");

	// The allocated count only grows within a table
	a_tally_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !final_byte |=> st_q.tally >= $past(st_q.tally))
		else $error("allocated count went down");

endmodule
